// ----- rtl/czc_pkg.sv -----
// ----------------------------------------------------------------------------
// czc_pkg
// Shared types and constants of the conveyor zone controller: register
// indexes, reset values, status codes and the configuration bundle.
// ----------------------------------------------------------------------------
package czc_pkg;

    // Widths of the configuration and payload fields
    localparam int TIME_W   = 16;
    localparam int DUTY_W   = 10;
    localparam int COUNT_W  = 8;
    localparam int PEER_W   = 8;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JAM_TIME    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIME   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_DUTY    = 8'd3;

    // Register reset values
    localparam logic [TIME_W-1:0] FILTER_TIME_RST = 16'd200;
    localparam logic [TIME_W-1:0] JAM_TIME_RST    = 16'd8000;
    localparam logic [TIME_W-1:0] IDLE_TIME_RST   = 16'd4000;
    localparam logic [DUTY_W-1:0] RUN_DUTY_RST    = 10'd800;

    // Highest PWM compare value and the peer fault status byte
    localparam logic [DUTY_W-1:0] DUTY_MAX        = 10'd1000;
    localparam logic [PEER_W-1:0] PEER_FAULT_CODE = 8'd2;

    // Reported zone status
    typedef enum logic [1:0] {
        ST_STOP = 2'd0,
        ST_RUN  = 2'd1,
        ST_JAM  = 2'd2
    } czc_status_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [TIME_W-1:0] filter_time;
        logic [TIME_W-1:0] jam_time;
        logic [TIME_W-1:0] idle_time;
        logic [DUTY_W-1:0] run_value;  // run duty, saturated to DUTY_MAX
    } czc_cfg_t;

endpackage

// ----- rtl/czc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// czc_cfg_regs
// Configuration register file: decodes write beats by index, holds the
// timing and duty registers and saturates the run duty to the PWM range.
// ----------------------------------------------------------------------------
module czc_cfg_regs
    import czc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output czc_cfg_t             cfg
);

    logic [TIME_W-1:0] filter_time_reg;
    logic [TIME_W-1:0] jam_time_reg;
    logic [TIME_W-1:0] idle_time_reg;
    logic [DUTY_W-1:0] run_duty_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the write beat; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_time_reg <= FILTER_TIME_RST;
            jam_time_reg    <= JAM_TIME_RST;
            idle_time_reg   <= IDLE_TIME_RST;
            run_duty_reg    <= RUN_DUTY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FILTER_TIME: filter_time_reg <= cfg_data;
                REG_JAM_TIME:    jam_time_reg    <= cfg_data;
                REG_IDLE_TIME:   idle_time_reg   <= cfg_data;
                REG_RUN_DUTY:    run_duty_reg    <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the run duty to the PWM range
    always_comb begin
        cfg.filter_time = filter_time_reg;
        cfg.jam_time    = jam_time_reg;
        cfg.idle_time   = idle_time_reg;
        cfg.run_value   = (run_duty_reg > DUTY_MAX) ? DUTY_MAX : run_duty_reg;
    end

endmodule

// ----- rtl/conveyor_zone_controller.sv -----
// ----------------------------------------------------------------------------
// conveyor_zone_controller
// One conveyor zone: debounces the box sensor, runs and stops the motor,
// counts departures, latches jams and flags changed report bytes.
//
// Usage:
//   The s_ channel carries one beat per millisecond tick: raw sensor level
//   (low = box present), reset button and the peer zone's status byte.
//   The m_ channel returns exactly one result beat per input beat: motor
//   duty, run status, occupancy, package count, lamp and the send flag.
//   The cfg_ channel writes filter_time, jam_time, idle_time and run_duty
//   by index; write only while no beat is in flight.
//   A beat passes one input register, then the tick evaluation into the
//   result register. Throughput is one beat per cycle while the receiver
//   does not stall; the tick update is a single pass of three elapsed-time
//   subtract-and-compare paths and flag logic.
//   When the receiver stalls, the result is held, one more beat waits in
//   the input register, and s_ready drops until the result is taken.
//   Reset clears all zone state and the tick counter and loads the
//   register defaults (200, 8000, 4000, 800).
// ----------------------------------------------------------------------------
module conveyor_zone_controller
    import czc_pkg::*;
#(
    parameter int TICK_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_sensor_level,
    input  logic                 s_button_pressed,
    input  logic [PEER_W-1:0]    s_peer_status,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_W-1:0]    m_motor_duty,
    output logic [1:0]           m_run_status,
    output logic                 m_occupied,
    output logic [COUNT_W-1:0]   m_package_count,
    output logic                 m_led_on,
    output logic                 m_send_frame,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    localparam int PAD_W = TICK_WIDTH - TIME_W;
    localparam int REPORT_W = 2 + COUNT_W + 1;

    czc_cfg_t cfg;

    // Input stage
    logic              in_vld_reg;
    logic              in_sensor_reg;
    logic              in_button_reg;
    logic [PEER_W-1:0] in_peer_reg;
    logic              advance;

    // Zone state
    logic [TICK_WIDTH-1:0] tick_reg,         tick_next;
    logic [TICK_WIDTH-1:0] filter_start_reg, filter_start_next;
    logic [TICK_WIDTH-1:0] jam_start_reg,    jam_start_next;
    logic [TICK_WIDTH-1:0] idle_start_reg,   idle_start_next;
    logic                  rise_armed_reg,   rise_armed_next;
    logic                  fall_armed_reg,   fall_armed_next;
    logic                  occupied_reg,     occupied_next;
    logic                  idle_done_reg,    idle_done_next;
    logic                  jam_reg,          jam_next;
    logic                  peer_fault_reg,   peer_fault_next;
    logic [COUNT_W-1:0]    count_reg,        count_next;
    czc_status_t           status_reg,       status_next;
    logic [DUTY_W-1:0]     duty_reg,         duty_next;
    logic [REPORT_W-1:0]   last_sent_reg,    last_sent_next;

    // Result stage
    logic                  m_valid_reg;
    logic [DUTY_W-1:0]     m_duty_reg;
    czc_status_t           m_status_reg;
    logic                  m_occupied_reg;
    logic [COUNT_W-1:0]    m_count_reg;
    logic                  m_send_reg;

    // Tick evaluation temporaries
    logic                  box;
    logic [TICK_WIDTH-1:0] el_filter;
    logic [TICK_WIDTH-1:0] el_jam;
    logic [TICK_WIDTH-1:0] el_idle;

    czc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: evaluate when the result slot is free or being emptied
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Capture input beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sensor_reg <= s_sensor_level;
            in_button_reg <= s_button_pressed;
            in_peer_reg   <= s_peer_status;
        end
    end

    // One tick of the zone controller
    always_comb begin
        box               = !in_sensor_reg;
        tick_next         = tick_reg + 1'b1;
        filter_start_next = filter_start_reg;
        jam_start_next    = jam_start_reg;
        idle_start_next   = idle_start_reg;
        rise_armed_next   = rise_armed_reg;
        fall_armed_next   = fall_armed_reg;
        occupied_next     = occupied_reg;
        idle_done_next    = idle_done_reg;
        jam_next          = jam_reg;
        count_next        = count_reg;
        status_next       = status_reg;
        duty_next         = duty_reg;

        // Arm the filter on a sensor change against the confirmed level
        if (box && !occupied_reg && !rise_armed_reg) begin
            filter_start_next = tick_reg;
            jam_start_next    = tick_reg;
            rise_armed_next   = 1'b1;
        end else if (!box) begin
            rise_armed_next = 1'b0;
        end
        if (!box && occupied_reg && !fall_armed_reg) begin
            filter_start_next = tick_reg;
            idle_start_next   = tick_reg;
            fall_armed_next   = 1'b1;
        end else if (box) begin
            fall_armed_next = 1'b0;
        end

        el_filter = tick_reg - filter_start_next;
        el_jam    = tick_reg - jam_start_next;
        el_idle   = tick_reg - idle_start_next;

        // Confirm arrival or departure once the filter time has passed
        if (el_filter >= {{PAD_W{1'b0}}, cfg.filter_time}) begin
            if (box && !occupied_reg) begin
                occupied_next  = 1'b1;
                idle_done_next = 1'b0;
                if (!jam_reg && !peer_fault_reg) begin
                    duty_next   = cfg.run_value;
                    status_next = ST_RUN;
                end
            end else if (!box && occupied_reg) begin
                occupied_next = 1'b0;
                count_next    = count_reg + 1'b1;
            end
        end

        // Standby stop after the idle time with no box
        if (el_idle >= {{PAD_W{1'b0}}, cfg.idle_time} && !idle_done_next && !box) begin
            duty_next      = '0;
            status_next    = ST_STOP;
            idle_done_next = 1'b1;
        end

        // Latch a jam when a box blocks the sensor too long
        if (el_jam >= {{PAD_W{1'b0}}, cfg.jam_time} && !peer_fault_reg && box) begin
            duty_next   = '0;
            jam_next    = 1'b1;
            status_next = ST_JAM;
        end

        // Button clears a jam and restarts the motor
        if (in_button_reg && jam_next) begin
            jam_next    = 1'b0;
            duty_next   = cfg.run_value;
            status_next = ST_RUN;
        end

        // Peer fault forces a stop
        if (in_peer_reg == PEER_FAULT_CODE) begin
            duty_next       = '0;
            status_next     = ST_STOP;
            peer_fault_next = 1'b1;
        end else begin
            peer_fault_next = 1'b0;
        end

        last_sent_next = {occupied_next, count_next, status_next};
    end

    // Advance zone state once per evaluated tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg         <= '0;
            filter_start_reg <= '0;
            jam_start_reg    <= '0;
            idle_start_reg   <= '0;
            rise_armed_reg   <= 1'b0;
            fall_armed_reg   <= 1'b0;
            occupied_reg     <= 1'b0;
            idle_done_reg    <= 1'b0;
            jam_reg          <= 1'b0;
            peer_fault_reg   <= 1'b0;
            count_reg        <= '0;
            status_reg       <= ST_STOP;
            duty_reg         <= '0;
            last_sent_reg    <= '0;
        end else if (advance) begin
            tick_reg         <= tick_next;
            filter_start_reg <= filter_start_next;
            jam_start_reg    <= jam_start_next;
            idle_start_reg   <= idle_start_next;
            rise_armed_reg   <= rise_armed_next;
            fall_armed_reg   <= fall_armed_next;
            occupied_reg     <= occupied_next;
            idle_done_reg    <= idle_done_next;
            jam_reg          <= jam_next;
            peer_fault_reg   <= peer_fault_next;
            count_reg        <= count_next;
            status_reg       <= status_next;
            duty_reg         <= duty_next;
            last_sent_reg    <= last_sent_next;
        end
    end

    // Result valid: set on a new result, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_duty_reg     <= duty_next;
            m_status_reg   <= status_next;
            m_occupied_reg <= occupied_next;
            m_count_reg    <= count_next;
            m_send_reg     <= (last_sent_next != last_sent_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_motor_duty    = m_duty_reg;
    assign m_run_status    = m_status_reg;
    assign m_occupied      = m_occupied_reg;
    assign m_package_count = m_count_reg;
    assign m_led_on        = m_occupied_reg;
    assign m_send_frame    = m_send_reg;

    // A jammed zone never drives the motor
    a_jam_stops_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg == ST_JAM |-> duty_reg == '0)
        else $error("jam status with nonzero motor duty");

    // Reported duty stays within the PWM range
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_motor_duty <= DUTY_MAX)
        else $error("motor duty above range");

    // Zone state moves only on an evaluated tick
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(count_reg) && $stable(tick_reg) && $stable(occupied_reg))
        else $error("zone state changed without a tick");

    // The package count steps by at most one per tick
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1)
        else $error("package count jumped");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the conveyor zone controller tick by tick. A driver sends tick beats
// in random bursts, the receiver stalls on its own pattern, and every result
// beat is compared field by field against a cycle-free zone predictor. The
// run walks through several register settings, extremes included, with
// short timing registers so that boxes confirm, jam and stop often.
// ----------------------------------------------------------------------------
module testbench
    import czc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_W = 32;

    // One tick beat as queued for the driver
    typedef struct packed {
        logic              sensor;
        logic              button;
        logic [PEER_W-1:0] peer;
    } tick_item_t;

    // One expected result beat
    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        czc_status_t        status;
        logic               occupied;
        logic [COUNT_W-1:0] count;
        logic               lamp;
        logic               send;
    } zone_report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_sensor_level   = 1'b1;
    logic                 s_button_pressed = 1'b0;
    logic [PEER_W-1:0]    s_peer_status    = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [DUTY_W-1:0]    m_motor_duty;
    logic [1:0]           m_run_status;
    logic                 m_occupied;
    logic [COUNT_W-1:0]   m_package_count;
    logic                 m_led_on;
    logic                 m_send_frame;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    conveyor_zone_controller #(
        .TICK_WIDTH(TICK_W)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_level  (s_sensor_level),
        .s_button_pressed(s_button_pressed),
        .s_peer_status   (s_peer_status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_motor_duty    (m_motor_duty),
        .m_run_status    (m_run_status),
        .m_occupied      (m_occupied),
        .m_package_count (m_package_count),
        .m_led_on        (m_led_on),
        .m_send_frame    (m_send_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predicted zone registers
    logic [TIME_W-1:0] cfg_filter = FILTER_TIME_RST;
    logic [TIME_W-1:0] cfg_jam    = JAM_TIME_RST;
    logic [TIME_W-1:0] cfg_idle   = IDLE_TIME_RST;
    logic [DUTY_W-1:0] cfg_duty   = RUN_DUTY_RST;

    // Predicted zone state
    logic [TICK_W-1:0]  tick_now        = '0;
    logic [TICK_W-1:0]  filt_start      = '0;
    logic [TICK_W-1:0]  jam_start       = '0;
    logic [TICK_W-1:0]  idle_start      = '0;
    logic               sens_confirmed  = 1'b0;
    logic               rise_armed      = 1'b0;
    logic               fall_armed      = 1'b0;
    logic               present_latched = 1'b0;
    logic               idle_stopped    = 1'b0;
    logic               jam_latched     = 1'b0;
    logic               peer_faulted    = 1'b0;
    logic [COUNT_W-1:0] box_cnt         = '0;
    czc_status_t        zone_status     = ST_STOP;
    logic               occ_flag        = 1'b0;
    logic [DUTY_W-1:0]  duty_now        = '0;
    logic               lamp_on         = 1'b0;
    logic [23:0]        last_report     = '0;

    tick_item_t   tick_queue[$];
    zone_report_t pending_reports[$];

    int unsigned pushed_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;

    // Advance the predicted zone by one tick and return its result beat
    function automatic zone_report_t zone_tick(tick_item_t item);
        zone_report_t      rep;
        logic              box;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] age;
        logic [DUTY_W-1:0] run_val;
        logic [23:0]       report_bytes;
        now     = tick_now;
        box     = !item.sensor;
        run_val = (cfg_duty > DUTY_MAX) ? DUTY_MAX : cfg_duty;

        // arm the filter on a sensor edge against the confirmed level
        if (box && !sens_confirmed && !rise_armed) begin
            filt_start = now;
            jam_start  = now;
            rise_armed = 1'b1;
        end else if (!box) begin
            rise_armed = 1'b0;
        end
        if (!box && sens_confirmed && !fall_armed) begin
            filt_start = now;
            idle_start = now;
            fall_armed = 1'b1;
        end else if (box) begin
            fall_armed = 1'b0;
        end

        // confirm arrival or departure once the filter time has passed
        age = now - filt_start;
        if (age >= cfg_filter) begin
            if (box && !present_latched) begin
                lamp_on         = 1'b1;
                occ_flag        = 1'b1;
                sens_confirmed  = 1'b1;
                present_latched = 1'b1;
                idle_stopped    = 1'b0;
                if (!jam_latched && !peer_faulted) begin
                    duty_now    = run_val;
                    zone_status = ST_RUN;
                end
            end else if (!box && present_latched) begin
                lamp_on         = 1'b0;
                occ_flag        = 1'b0;
                box_cnt         = box_cnt + 1'b1;
                present_latched = 1'b0;
                sens_confirmed  = 1'b0;
            end
        end

        // standby stop after the idle time with no box
        age = now - idle_start;
        if (age >= cfg_idle && !idle_stopped && !box) begin
            duty_now     = '0;
            zone_status  = ST_STOP;
            idle_stopped = 1'b1;
        end

        // latch a jam when the box blocks the sensor too long
        age = now - jam_start;
        if (age >= cfg_jam && !peer_faulted && box) begin
            duty_now    = '0;
            jam_latched = 1'b1;
            zone_status = ST_JAM;
        end

        // button clears the jam and restarts the motor
        if (item.button && jam_latched) begin
            jam_latched = 1'b0;
            duty_now    = run_val;
            zone_status = ST_RUN;
        end

        // neighbour fault forces a stop
        if (item.peer == PEER_FAULT_CODE) begin
            duty_now     = '0;
            zone_status  = ST_STOP;
            peer_faulted = 1'b1;
        end else begin
            peer_faulted = 1'b0;
        end

        report_bytes = {7'd0, occ_flag, box_cnt, 6'd0, zone_status};
        rep.duty     = duty_now;
        rep.status   = zone_status;
        rep.occupied = occ_flag;
        rep.count    = box_cnt;
        rep.lamp     = lamp_on;
        rep.send     = (report_bytes != last_report);
        last_report  = report_bytes;
        tick_now     = tick_now + 1'b1;
        return rep;
    endfunction

    function automatic void queue_fixed(logic sensor, logic button, logic [PEER_W-1:0] peer);
        tick_item_t item;
        item.sensor = sensor;
        item.button = button;
        item.peer   = peer;
        tick_queue.push_back(item);
        pushed_count++;
    endfunction

    // Queue one tick with a random button and peer byte
    function automatic void queue_random(logic sensor, bit fault_mode);
        logic [PEER_W-1:0] peer;
        peer = PEER_W'($urandom_range(0, 255));
        if ((fault_mode && $urandom_range(0, 2) == 0) || $urandom_range(0, 29) == 0)
            peer = PEER_FAULT_CODE;
        queue_fixed(sensor, $urandom_range(0, 15) == 0, peer);
    endfunction

    // Mostly whole box passages sized to the timing registers, some sensor noise
    function automatic void queue_traffic(int unsigned count);
        int unsigned made;
        int unsigned len;
        int unsigned max_hold;
        int unsigned max_gap;
        bit          fault_mode;
        made     = 0;
        max_hold = cfg_filter + cfg_jam + 8;
        max_gap  = cfg_filter + cfg_idle + 8;
        if (max_hold > 80) max_hold = 80;
        if (max_gap > 60) max_gap = 60;
        while (made < count) begin
            fault_mode = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(1, max_hold);
                repeat (len) queue_random(1'b0, fault_mode);
                made += len;
                len = $urandom_range(1, max_gap);
                repeat (len) queue_random(1'b1, fault_mode);
                made += len;
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) queue_random(1'($urandom_range(0, 1)), fault_mode);
                made += len;
            end
        end
    endfunction

    // Write one register; the channel stays valid until the writes are closed
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FILTER_TIME: cfg_filter = data;
            REG_JAM_TIME:    cfg_jam    = data;
            REG_IDLE_TIME:   cfg_idle   = data;
            REG_RUN_DUTY:    cfg_duty   = data[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [TIME_W-1:0] filter, logic [TIME_W-1:0] jam,
                              logic [TIME_W-1:0] idle, logic [TIME_W-1:0] duty);
        write_reg(REG_FILTER_TIME, filter);
        write_reg(REG_JAM_TIME, jam);
        write_reg(REG_IDLE_TIME, idle);
        write_reg(REG_RUN_DUTY, duty);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every tick is taken and every result checked, then let it settle
    task automatic wait_idle();
        while (accepted_count != pushed_count || pending_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Tick driver: bursts of random length with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic        tick_taken = 1'b0;
    tick_item_t  next_tick;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tick_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                next_tick = tick_queue.pop_front();
                s_sensor_level   <= next_tick.sensor;
                s_button_pressed <= next_tick.button;
                s_peer_status    <= next_tick.peer;
                s_valid          <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    if ($urandom_range(0, 15) == 0)
                        gap_left <= $urandom_range(20, 40);
                    else if ($urandom_range(0, 2) == 0)
                        gap_left <= $urandom_range(1, 8);
                    else
                        gap_left <= 0;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Record accepted ticks and predict their results
    always @(posedge aclk) begin
        tick_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pending_reports.push_back(zone_tick({s_sensor_level, s_button_pressed,
                                                 s_peer_status}));
            accepted_count++;
        end
    end

    // Result receiver: runs of ready and stall, now and then a long ready stretch
    int unsigned ready_left = 0;

    always @(negedge aclk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(50, 200);
        end else if ($urandom_range(0, 1) == 0) begin
            m_ready    <= 1'b0;
            ready_left <= $urandom_range(1, 8);
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(1, 20);
        end
    end

    // Check each result beat against the oldest prediction
    zone_report_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no tick pending");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_motor_duty !== want.duty) begin
                    $error("motor_duty: expected %0d, got %0d", want.duty, m_motor_duty);
                    mismatch_count++;
                end
                if (m_run_status !== want.status) begin
                    $error("run_status: expected %0d, got %0d", want.status, m_run_status);
                    mismatch_count++;
                end
                if (m_occupied !== want.occupied) begin
                    $error("occupied: expected %0d, got %0d", want.occupied, m_occupied);
                    mismatch_count++;
                end
                if (m_package_count !== want.count) begin
                    $error("package_count: expected %0d, got %0d",
                           want.count, m_package_count);
                    mismatch_count++;
                end
                if (m_led_on !== want.lamp) begin
                    $error("led_on: expected %0d, got %0d", want.lamp, m_led_on);
                    mismatch_count++;
                end
                if (m_send_frame !== want.send) begin
                    $error("send_frame: expected %0d, got %0d", want.send, m_send_frame);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: raw levels and peer byte extremes
        queue_fixed(1'b1, 1'b0, 8'd0);
        queue_fixed(1'b0, 1'b1, 8'd255);
        queue_fixed(1'b1, 1'b0, PEER_FAULT_CODE);
        queue_fixed(1'b0, 1'b0, PEER_FAULT_CODE);
        wait_idle();

        // no filtering, short jam and idle, run duty above range
        write_reg(8'd4, 16'hFFFF);
        write_reg(8'hFF, 16'h0000);
        set_config(16'd0, 16'd3, 16'd2, 16'hFFFF);

        // arrival, jam, button clear, peer fault, jam again, departure,
        // standby stop, button while jammed with no box, arrival under fault
        repeat (4) queue_fixed(1'b0, 1'b0, 8'd0);
        queue_fixed(1'b0, 1'b1, 8'd0);
        queue_fixed(1'b0, 1'b0, PEER_FAULT_CODE);
        queue_fixed(1'b0, 1'b0, 8'd255);
        queue_fixed(1'b0, 1'b0, 8'd0);
        repeat (3) queue_fixed(1'b1, 1'b0, 8'h01);
        queue_fixed(1'b1, 1'b1, 8'h80);
        queue_fixed(1'b1, 1'b0, PEER_FAULT_CODE);
        queue_fixed(1'b0, 1'b0, 8'h7F);
        queue_fixed(1'b0, 1'b0, 8'h03);
        queue_fixed(1'b1, 1'b0, 8'hFE);
        wait_idle();

        // random traffic under a series of register settings
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_config(16'd0, 16'd0, 16'd0, 16'd0);
                1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000);
                2: set_config(TIME_W'($urandom_range(0, 6)), TIME_W'($urandom_range(0, 40)),
                              TIME_W'($urandom_range(0, 30)), 16'hFFFF);
                default: set_config(TIME_W'($urandom_range(0, 6)),
                                    TIME_W'($urandom_range(0, 40)),
                                    TIME_W'($urandom_range(0, 30)),
                                    {6'($urandom_range(0, 63)), 10'($urandom_range(0, 1023))});
            endcase
            queue_traffic((p == 1) ? 60 : 200);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
